// ===== sv/mdr_pkg.sv =====
// types, constants and the arctangent table for the mecanum dead reckoning block
`default_nettype none
package mdr_pkg;

	typedef struct packed {
		logic               mode;
		logic               read_ok;
		logic signed [31:0] enc_front_left;
		logic signed [31:0] enc_front_right;
		logic signed [31:0] enc_rear_left;
		logic signed [31:0] enc_rear_right;
		logic signed [15:0] heading;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading_out;
		logic               pose_valid;
	} rsp_t;

	localparam int GAIN_W   = 24;
	localparam int TABLE_LEN = 24;

	// register indexes
	localparam logic REG_FORWARD_GAIN = 1'b0;
	localparam logic REG_SIDE_GAIN    = 1'b1;

	localparam logic signed [GAIN_W-1:0] GAIN_RESET = 24'sd65536;

	// round(2^32 / (2000 * cordic gain))
	localparam logic signed [24:0] INV_GAIN_DIV = 25'sd1304066;

	localparam logic signed [63:0] VEC_LIMIT    = 64'sd274877906944;
	localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

	// atan(2^-i), full circle 2^32
	function automatic logic [29:0] atan_lut(input logic [4:0] idx);
		logic [29:0] v;
		unique case (idx)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004755;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== sv/mecanum_dead_reckoning.sv =====
// mecanum wheel dead reckoning: encoder deltas, gain scaling, cordic rotation, saturating pose
//
// usage
//   request channel (req_valid, req_stall, req): one sample or zero command per request.
//   response channel (rsp_valid, rsp_stall, rsp): exactly one pose per request, in order.
//   config port (cfg_we, cfg_index, cfg_data): index 0 forward gain, 1 side gain, written
//   only while no request is in flight.
// sequence and throughput
//   a zero command, a failed read or a base sample: acceptance goes straight to the final state,
//   which registers the response; the next request is taken once the response has been taken.
//   an integrating sample: delta sums, forward and side gain products, fold, cordic rotations,
//   x and y scaling with saturating adds, then the final state; the next request as above. the
//   length is set by the one shared 22x25 multiplier used for eight partial products and by the
//   cordic stage that does one rotation per cycle. one request is in work at a time.
// stalls
//   the response waits in an output register while rsp_stall is high; req_stall stays
//   high until it is taken.
// reset
//   pose and base counts clear, gains return to 1.0, the next good sample sets the base.
`default_nettype none
module mecanum_dead_reckoning #(
	parameter int CORDIC_STEPS  = 16,
	parameter int POS_FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire mdr_pkg::req_t                 req,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output mdr_pkg::rsp_t                      rsp,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [mdr_pkg::GAIN_W-1:0]    cfg_data
);
	import mdr_pkg::*;

	localparam int CW = 42;
	localparam int ZW = 34;
	localparam int AW = 64;
	localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam logic [4:0] LAST_IT = 5'(NSTEPS - 1);
	localparam int SHR = 48 - POS_FRAC_BITS;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SUM  = 5'd1;
	localparam logic [4:0] S_MF0  = 5'd2;
	localparam logic [4:0] S_MF1  = 5'd3;
	localparam logic [4:0] S_MF2  = 5'd4;
	localparam logic [4:0] S_MS0  = 5'd5;
	localparam logic [4:0] S_MS1  = 5'd6;
	localparam logic [4:0] S_MS2  = 5'd7;
	localparam logic [4:0] S_ROT  = 5'd8;
	localparam logic [4:0] S_CORD = 5'd9;
	localparam logic [4:0] S_MX0  = 5'd10;
	localparam logic [4:0] S_MX1  = 5'd11;
	localparam logic [4:0] S_MX2  = 5'd12;
	localparam logic [4:0] S_MY0  = 5'd13;
	localparam logic [4:0] S_MY1  = 5'd14;
	localparam logic [4:0] S_MY2  = 5'd15;
	localparam logic [4:0] S_AY   = 5'd16;
	localparam logic [4:0] S_FIN  = 5'd17;

	function automatic logic signed [39:0] clamp_vec(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] s;
		logic signed [AW-1:0] r;
		s = v >>> 2;
		if (s > VEC_LIMIT) begin
			r = VEC_LIMIT;
		end else if (s < -VEC_LIMIT) begin
			r = -VEC_LIMIT;
		end else begin
			r = s;
		end
		return r[39:0];
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [AW-1:0] inc);
		logic signed [AW-1:0] s;
		logic signed [31:0] r;
		s = {{(AW-32){a[31]}}, a} + inc;
		if (s > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (s < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	logic [4:0]                state_q;
	logic                      rsp_valid_q;
	rsp_t                      rsp_q;
	logic signed [GAIN_W-1:0]  fwd_gain_q;
	logic signed [GAIN_W-1:0]  side_gain_q;
	logic signed [31:0]        prev_q [4];
	logic signed [31:0]        ax_q;
	logic signed [31:0]        ay_q;
	logic signed [15:0]        held_hd_q;
	logic                      first_q;
	logic                      rebase_q;
	logic                      vflag_q;

	logic signed [31:0]        enc_q [4];
	logic signed [15:0]        hd_q;
	logic signed [34:0]        fsum_q;
	logic signed [34:0]        ssum_q;
	logic signed [46:0]        prod_q;
	logic signed [AW-1:0]      acc_q;
	logic signed [39:0]        vx_q;
	logic signed [CW-1:0]      cx_q;
	logic signed [CW-1:0]      cy_q;
	logic signed [ZW-1:0]      cz_q;
	logic [4:0]                it_q;

	logic                      req_acc;
	logic signed [21:0]        mul_a;
	logic signed [24:0]        mul_b;
	logic signed [46:0]        prod_c;
	logic signed [AW-1:0]      prod_ext;
	logic signed [32:0]        d [4];
	logic signed [34:0]        fsum_c;
	logic signed [34:0]        ssum_c;
	logic signed [39:0]        vy_c;
	logic signed [CW-1:0]      vxe;
	logic signed [CW-1:0]      vye;
	logic signed [ZW-1:0]      z0;
	logic signed [CW-1:0]      xs;
	logic signed [CW-1:0]      ys;
	logic signed [ZW-1:0]      at;
	logic signed [AW-1:0]      inc_c;

	assign req_stall = (state_q != S_IDLE) || rsp_valid_q;
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MF0: begin
				mul_a = {4'b0, fsum_q[17:0]};
				mul_b = {fwd_gain_q[GAIN_W-1], fwd_gain_q};
			end
			S_MF1: begin
				mul_a = {{5{fsum_q[34]}}, fsum_q[34:18]};
				mul_b = {fwd_gain_q[GAIN_W-1], fwd_gain_q};
			end
			S_MS0: begin
				mul_a = {4'b0, ssum_q[17:0]};
				mul_b = {side_gain_q[GAIN_W-1], side_gain_q};
			end
			S_MS1: begin
				mul_a = {{5{ssum_q[34]}}, ssum_q[34:18]};
				mul_b = {side_gain_q[GAIN_W-1], side_gain_q};
			end
			S_MX0: begin
				mul_a = {1'b0, cx_q[20:0]};
				mul_b = INV_GAIN_DIV;
			end
			S_MX1: begin
				mul_a = {cx_q[CW-1], cx_q[CW-1:21]};
				mul_b = INV_GAIN_DIV;
			end
			S_MY0: begin
				mul_a = {1'b0, cy_q[20:0]};
				mul_b = INV_GAIN_DIV;
			end
			S_MY1: begin
				mul_a = {cy_q[CW-1], cy_q[CW-1:21]};
				mul_b = INV_GAIN_DIV;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_c   = 47'(mul_a) * 47'(mul_b);
	assign prod_ext = {{(AW-47){prod_q[46]}}, prod_q};

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			d[k] = {enc_q[k][31], enc_q[k]} - {prev_q[k][31], prev_q[k]};
		end
	end

	// mecanum forward and side pulse sums
	assign fsum_c = 35'(d[0]) - 35'(d[1]) + 35'(d[2]) - 35'(d[3]);
	assign ssum_c = 35'(d[2]) + 35'(d[3]) - 35'(d[0]) - 35'(d[1]);

	assign vy_c = clamp_vec(acc_q);
	assign vxe  = {{(CW-40){vx_q[39]}}, vx_q};
	assign vye  = {{(CW-40){vy_c[39]}}, vy_c};
	assign z0   = {{(ZW-32){hd_q[15]}}, hd_q, 16'b0};
	assign xs   = cx_q >>> it_q;
	assign ys   = cy_q >>> it_q;
	assign at   = {{(ZW-30){1'b0}}, atan_lut(it_q)};
	assign inc_c = acc_q >>> SHR;

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			fwd_gain_q  <= GAIN_RESET;
			side_gain_q <= GAIN_RESET;
			for (int k = 0; k < 4; k++) begin
				prev_q[k] <= '0;
			end
			ax_q      <= '0;
			ay_q      <= '0;
			held_hd_q <= '0;
			first_q   <= 1'b1;
			rebase_q  <= 1'b0;
			vflag_q   <= 1'b0;
			it_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FORWARD_GAIN: fwd_gain_q  <= cfg_data;
					REG_SIDE_GAIN:    side_gain_q <= cfg_data;
					default:          fwd_gain_q  <= fwd_gain_q;
				endcase
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						priority if (req.mode) begin
							ax_q     <= '0;
							ay_q     <= '0;
							rebase_q <= 1'b1;
							state_q  <= S_FIN;
						end else if (!req.read_ok) begin
							vflag_q <= 1'b0;
							state_q <= S_FIN;
						end else if (rebase_q || first_q) begin
							if (rebase_q) begin
								rebase_q <= 1'b0;
							end else begin
								first_q <= 1'b0;
							end
							prev_q[0] <= req.enc_front_left;
							prev_q[1] <= req.enc_front_right;
							prev_q[2] <= req.enc_rear_left;
							prev_q[3] <= req.enc_rear_right;
							vflag_q   <= 1'b1;
							state_q   <= S_FIN;
						end else begin
							vflag_q   <= 1'b1;
							held_hd_q <= req.heading;
							state_q   <= S_SUM;
						end
					end
				end
				S_SUM: begin
					for (int k = 0; k < 4; k++) begin
						prev_q[k] <= enc_q[k];
					end
					state_q <= S_MF0;
				end
				S_MF0: state_q <= S_MF1;
				S_MF1: state_q <= S_MF2;
				S_MF2: state_q <= S_MS0;
				S_MS0: state_q <= S_MS1;
				S_MS1: state_q <= S_MS2;
				S_MS2: state_q <= S_ROT;
				S_ROT: begin
					it_q    <= '0;
					state_q <= S_CORD;
				end
				S_CORD: begin
					it_q <= it_q + 5'd1;
					if (it_q == LAST_IT) begin
						state_q <= S_MX0;
					end
				end
				S_MX0: state_q <= S_MX1;
				S_MX1: state_q <= S_MX2;
				S_MX2: state_q <= S_MY0;
				S_MY0: begin
					ax_q    <= sat_add(ax_q, inc_c);
					state_q <= S_MY1;
				end
				S_MY1: state_q <= S_MY2;
				S_MY2: state_q <= S_AY;
				S_AY: begin
					ay_q    <= sat_add(ay_q, inc_c);
					state_q <= S_FIN;
				end
				S_FIN: begin
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		if (req_acc) begin
			enc_q[0] <= req.enc_front_left;
			enc_q[1] <= req.enc_front_right;
			enc_q[2] <= req.enc_rear_left;
			enc_q[3] <= req.enc_rear_right;
			hd_q     <= req.heading;
		end
		unique case (state_q)
			S_SUM: begin
				fsum_q <= fsum_c;
				ssum_q <= ssum_c;
			end
			S_MF1, S_MS1, S_MX1, S_MY1: begin
				acc_q <= prod_ext;
			end
			S_MF2, S_MS2: begin
				acc_q <= acc_q + (prod_ext <<< 18);
			end
			S_MX2, S_MY2: begin
				acc_q <= acc_q + (prod_ext <<< 21);
			end
			S_MS0: begin
				vx_q <= clamp_vec(acc_q);
			end
			S_ROT: begin
				// fold headings past a quarter turn into the cordic range
				if (z0 > QUARTER_TURN) begin
					cx_q <= -vxe;
					cy_q <= -vye;
					cz_q <= z0 - HALF_TURN;
				end else if (z0 < -QUARTER_TURN) begin
					cx_q <= -vxe;
					cy_q <= -vye;
					cz_q <= z0 + HALF_TURN;
				end else begin
					cx_q <= vxe;
					cy_q <= vye;
					cz_q <= z0;
				end
			end
			S_CORD: begin
				if (!cz_q[ZW-1]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end
			end
			S_FIN: begin
				rsp_q.pos_x       <= ax_q;
				rsp_q.pos_y       <= ay_q;
				rsp_q.heading_out <= held_hd_q;
				rsp_q.pose_valid  <= vflag_q;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== tb/sv/mdr_checker.sv =====
// pose predictor and response checker for the mecanum dead reckoning block
`timescale 1ns / 100ps
module mdr_checker #(
	parameter int CORDIC_STEPS  = 16,
	parameter int POS_FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_stall,
	input  mdr_pkg::req_t                req,
	input  logic                         rsp_valid,
	input  logic                         rsp_stall,
	input  mdr_pkg::rsp_t                rsp,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [mdr_pkg::GAIN_W-1:0]   cfg_data,
	output int                           fails,
	output int                           waiting,
	output int                           compared
);

	localparam longint VEC_CLAMP      = longint'(1) << 38;
	localparam longint RIGHT_ANGLE    = longint'(1) << 30;
	localparam longint STRAIGHT_ANGLE = longint'(1) << 31;
	localparam longint DIST_SCALE     = 1304066;
	localparam longint POS_MAX        = 64'sd2147483647;
	localparam longint POS_MIN        = -64'sd2147483648;

	// atan(2^-i) on a 2^32 circle
	longint atan_angle [24] = '{
		536870912, 316933406, 167458907, 85004755, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	logic signed [31:0] base_count [4];
	logic signed [31:0] pose_x;
	logic signed [31:0] pose_y;
	logic signed [15:0] last_heading;
	logic               first_sample;
	logic               rebase_due;
	logic               pose_ok;
	logic signed [23:0] fwd_gain;
	logic signed [23:0] lat_gain;
	mdr_pkg::rsp_t      expected_pose [$];

	task automatic report_mismatch(input string what);
		if (fails < 40)
			$display("[%0t] mismatch: %s", $time, what);
		fails++;
	endtask

	function automatic logic signed [31:0] sat_pos(input logic signed [31:0] acc, input longint inc);
		longint s;
		s = longint'(acc) + inc;
		if (s > POS_MAX)
			return POS_MAX[31:0];
		if (s < POS_MIN)
			return POS_MIN[31:0];
		return s[31:0];
	endfunction

	function automatic mdr_pkg::rsp_t predict_pose(input mdr_pkg::req_t r);
		logic signed [31:0] enc [4];
		longint d [4];
		longint fwd, lat, x, y, z, t;
		int i;
		mdr_pkg::rsp_t p;
		enc[0] = r.enc_front_left;
		enc[1] = r.enc_front_right;
		enc[2] = r.enc_rear_left;
		enc[3] = r.enc_rear_right;
		if (r.mode) begin
			pose_x = '0;
			pose_y = '0;
			rebase_due = 1'b1;
		end else if (!r.read_ok) begin
			pose_ok = 1'b0;
		end else if (rebase_due || first_sample) begin
			if (rebase_due)
				rebase_due = 1'b0;
			else
				first_sample = 1'b0;
			base_count = enc;
			pose_ok = 1'b1;
		end else begin
			for (i = 0; i < 4; i++)
				d[i] = longint'($signed(enc[i])) - longint'($signed(base_count[i]));
			fwd = d[0] - d[1] + d[2] - d[3];
			lat = -d[0] - d[1] + d[2] + d[3];
			x = (fwd * longint'($signed(fwd_gain))) >>> 2;
			y = (lat * longint'($signed(lat_gain))) >>> 2;
			if (x > VEC_CLAMP)
				x = VEC_CLAMP;
			else if (x < -VEC_CLAMP)
				x = -VEC_CLAMP;
			if (y > VEC_CLAMP)
				y = VEC_CLAMP;
			else if (y < -VEC_CLAMP)
				y = -VEC_CLAMP;
			z = longint'($signed(r.heading)) * 65536;
			// fold the back half plane onto the front one
			if (z > RIGHT_ANGLE) begin
				x = -x;
				y = -y;
				z = z - STRAIGHT_ANGLE;
			end else if (z < -RIGHT_ANGLE) begin
				x = -x;
				y = -y;
				z = z + STRAIGHT_ANGLE;
			end
			for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
				if (z >= 0) begin
					t = x - (y >>> i);
					y = y + (x >>> i);
					z = z - atan_angle[i];
				end else begin
					t = x + (y >>> i);
					y = y - (x >>> i);
					z = z + atan_angle[i];
				end
				x = t;
			end
			pose_x = sat_pos(pose_x, (x * DIST_SCALE) >>> (48 - POS_FRAC_BITS));
			pose_y = sat_pos(pose_y, (y * DIST_SCALE) >>> (48 - POS_FRAC_BITS));
			last_heading = r.heading;
			base_count = enc;
			pose_ok = 1'b1;
		end
		p.pos_x = pose_x;
		p.pos_y = pose_y;
		p.heading_out = last_heading;
		p.pose_valid = pose_ok;
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mdr_pkg::rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				base_count[i] = '0;
			pose_x = '0;
			pose_y = '0;
			last_heading = '0;
			first_sample = 1'b1;
			rebase_due = 1'b0;
			pose_ok = 1'b0;
			fwd_gain = mdr_pkg::GAIN_RESET;
			lat_gain = mdr_pkg::GAIN_RESET;
			expected_pose.delete();
			fails = 0;
			waiting = 0;
			compared = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mdr_pkg::REG_FORWARD_GAIN: fwd_gain = cfg_data;
					mdr_pkg::REG_SIDE_GAIN:    lat_gain = cfg_data;
					default: report_mismatch("gain write with unknown index");
				endcase
			end
			if (req_valid && !req_stall) begin
				expected_pose.push_back(predict_pose(req));
				waiting++;
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_pose.size() == 0) begin
					report_mismatch($sformatf("pose with no request waiting: x=%0d y=%0d",
						$signed(rsp.pos_x), $signed(rsp.pos_y)));
				end else begin
					want = expected_pose.pop_front();
					waiting--;
					compared++;
					if (rsp.pos_x !== want.pos_x)
						report_mismatch($sformatf("pose %0d pos_x got %0d want %0d", compared,
							$signed(rsp.pos_x), $signed(want.pos_x)));
					if (rsp.pos_y !== want.pos_y)
						report_mismatch($sformatf("pose %0d pos_y got %0d want %0d", compared,
							$signed(rsp.pos_y), $signed(want.pos_y)));
					if (rsp.heading_out !== want.heading_out)
						report_mismatch($sformatf("pose %0d heading_out got %0d want %0d",
							compared, $signed(rsp.heading_out), $signed(want.heading_out)));
					if (rsp.pose_valid !== want.pose_valid)
						report_mismatch($sformatf("pose %0d pose_valid got %b want %b", compared,
							rsp.pose_valid, want.pose_valid));
				end
			end
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// clock, reset, request stimulus and verdict for the mecanum dead reckoning block
`timescale 1ns / 100ps
module tb_top;
	import mdr_pkg::*;

	localparam int CORDIC_STEPS   = 16;
	localparam int POS_FRAC_BITS  = 16;
	localparam int SETTLE         = CORDIC_STEPS + 24;
	localparam int PHASES         = 8;
	localparam int PHASE_REQUESTS = 138;
	localparam int CYCLE_LIMIT    = 600000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_t              rsp;
	logic              cfg_we = 1'b0;
	logic              cfg_index = REG_FORWARD_GAIN;
	logic [GAIN_W-1:0] cfg_data = '0;
	int                fails;
	int                waiting;
	int                compared;

	logic              sender_busy = 1'b0;
	logic              rsp_busy = 1'b0;
	int                burst_left = 0;
	int                stall_run = 0;
	int                cycle_count = 0;
	int                requests_sent = 0;
	int                zero_reqs = 0;
	int                failed_reads = 0;
	int                streaks = 0;
	logic [31:0]       last_enc [4] = '{default: '0};
	logic [GAIN_W-1:0] fwd_setting [PHASES];
	logic [GAIN_W-1:0] lat_setting [PHASES];

	mecanum_dead_reckoning #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.POS_FRAC_BITS(POS_FRAC_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	mdr_checker #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.POS_FRAC_BITS(POS_FRAC_BITS)
	) pose_chk (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fails(fails),
		.waiting(waiting),
		.compared(compared)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// response side backpressure
	always @(negedge clk) begin
		if (stall_run > 0) begin
			stall_run--;
		end else if (!rsp_busy) begin
			rsp_stall = 1'b0;
			stall_run = 8;
		end else begin
			rsp_stall = ($urandom_range(0, 99) < 35);
			stall_run = rsp_stall ? $urandom_range(0, 40) : $urandom_range(0, 30);
		end
	end

	function automatic req_t make_req(input logic mode, input logic ok, input logic [31:0] fl,
			input logic [31:0] fr, input logic [31:0] rl, input logic [31:0] rr,
			input logic [15:0] hd);
		req_t r;
		r.mode = mode;
		r.read_ok = ok;
		r.enc_front_left = fl;
		r.enc_front_right = fr;
		r.enc_rear_left = rl;
		r.enc_rear_right = rr;
		r.heading = hd;
		return r;
	endfunction

	function automatic req_t drive_req(input int spread, input logic [15:0] hd);
		return make_req(1'b0, 1'b1,
			last_enc[0] + $urandom_range(0, 2 * spread) - spread,
			last_enc[1] + $urandom_range(0, 2 * spread) - spread,
			last_enc[2] + $urandom_range(0, 2 * spread) - spread,
			last_enc[3] + $urandom_range(0, 2 * spread) - spread, hd);
	endfunction

	function automatic logic [15:0] pick_heading();
		if ($urandom_range(0, 3) != 0)
			return 16'($urandom);
		case ($urandom_range(0, 6))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h4000;
			3: return 16'h4001;
			4: return 16'hc000;
			5: return 16'hbfff;
			default: return 16'h0000;
		endcase
	endfunction

	task automatic send_req(input req_t r);
		@(negedge clk);
		if (sender_busy && burst_left == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 40)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		req = r;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		requests_sent++;
		if (r.mode) begin
			zero_reqs++;
		end else begin
			if (!r.read_ok)
				failed_reads++;
			last_enc = '{r.enc_front_left, r.enc_front_right, r.enc_rear_left, r.enc_rear_right};
		end
	endtask

	// full scale wheel swings with the heading turned half a circle every other
	// request, so each step after the first pushes the pose the same way
	task automatic send_streak(input int len);
		logic [15:0] hd;
		int k;
		hd = 16'($urandom);
		streaks++;
		for (k = 0; k < len; k++) begin
			if (k % 2 == 0)
				send_req(make_req(1'b0, 1'b1, '0, 32'h8000_0000, 32'h7fff_ffff, '0, hd));
			else
				send_req(make_req(1'b0, 1'b1, '0, 32'h7fff_ffff, 32'h8000_0000, '0, hd + 16'h8000));
		end
	endtask

	task automatic drain_poses();
		@(negedge clk);
		req_valid = 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_gain(input logic idx, input logic [GAIN_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		int phase;
		int target;
		int pick;
		fwd_setting = '{24'd65536, 24'h7fffff, 24'h800000, 24'd0, 24'hffffff, 24'd0, 24'd0,
			24'd65536};
		lat_setting = '{24'd65536, 24'h7fffff, 24'h800000, 24'd1, 24'h7fffff, 24'd0,
			24'h800000, 24'hff0000};
		fwd_setting[5] = 24'($urandom);
		fwd_setting[6] = 24'($urandom);
		lat_setting[5] = 24'($urandom);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: first sample handling, rebase, heading edges, huge deltas
		send_req(make_req(1'b0, 1'b0, 32'd11, 32'd22, 32'd33, 32'd44, 16'h1234));
		send_req(make_req(1'b1, 1'b0, '1, '1, '1, '1, 16'h7fff));
		send_req(make_req(1'b0, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 16'd100));
		send_req(make_req(1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 16'd200));
		send_req(make_req(1'b0, 1'b1, 32'h8000_03e8, 32'h8000_012c, 32'h8000_0032,
			32'h8000_0007, 16'h0000));
		send_req(drive_req(1000, 16'h7fff));
		send_req(drive_req(1000, 16'h8000));
		send_req(drive_req(1000, 16'h4000));
		send_req(drive_req(1000, 16'h4001));
		send_req(drive_req(1000, 16'hc000));
		send_req(drive_req(1000, 16'hbfff));
		send_req(make_req(1'b0, 1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 16'h0000));
		send_req(make_req(1'b0, 1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 16'h2000));
		send_req(make_req(1'b0, 1'b0, $urandom, $urandom, $urandom, $urandom, 16'd5));
		send_req(drive_req(1000, 16'h0100));
		send_req(make_req(1'b1, 1'b1, $urandom, $urandom, $urandom, $urandom,
			16'($urandom)));
		send_req(drive_req(5000, 16'h0200));
		send_req(drive_req(1000, 16'hf000));
		send_req(make_req(1'b1, 1'b1, '0, '0, '0, '0, 16'h0000));
		send_req(make_req(1'b0, 1'b0, $urandom, $urandom, $urandom, $urandom,
			16'($urandom)));
		send_req(drive_req(1000, 16'h0300));
		send_req(drive_req(1000, 16'h6000));

		for (phase = 0; phase < PHASES; phase++) begin
			drain_poses();
			write_gain(REG_FORWARD_GAIN, fwd_setting[phase]);
			write_gain(REG_SIDE_GAIN, lat_setting[phase]);
			sender_busy = (phase % 3 != 0);
			rsp_busy = (phase % 4 != 0);
			burst_left = 0;
			target = requests_sent + PHASE_REQUESTS;
			while (requests_sent < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					send_req(drive_req(($urandom_range(0, 9) == 0) ? (1 << 24) : 1000,
						pick_heading()));
				else if (pick < 65)
					send_streak($urandom_range(1, 24));
				else if (pick < 73)
					send_req(make_req(1'b0, 1'b1, $urandom, $urandom, $urandom, $urandom,
						16'($urandom)));
				else if (pick < 85)
					send_req(make_req(1'b0, 1'b0, $urandom, $urandom, $urandom, $urandom,
						16'($urandom)));
				else if (pick < 93)
					send_req(make_req(1'b1, 1'($urandom), $urandom, $urandom, $urandom,
						$urandom, 16'($urandom)));
				else if (pick < 97)
					send_req(drive_req(0, pick_heading()));
				else
					drain_poses();
			end
		end

		drain_poses();
		$display("%0d requests (%0d zero, %0d failed reads, %0d drive streaks), %0d poses checked",
			requests_sent, zero_reqs, failed_reads, streaks, compared);
		$display("gain pairs exercised: reset plus %0d written settings incl. both extremes",
			PHASES);
		if (fails == 0)
			$display("mecanum_dead_reckoning test passed");
		else
			$display("mecanum_dead_reckoning test failed");
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("cycle limit %0d reached with %0d poses outstanding", CYCLE_LIMIT, waiting);
		$display("mecanum_dead_reckoning test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/mdr_pkg.sv
sv/mecanum_dead_reckoning.sv
tb/sv/mdr_checker.sv
tb/sv/tb_top.sv
